[hdl/pbat_pkg.sv]
package pbat_pkg;

    localparam int HEADS_DEF       = 4;
    localparam int BLOCKS_DEF      = 10240;
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int FIFO_DEPTH      = 2;

    localparam int IN_W  = 72;
    localparam int OUT_W = 104;

    localparam logic [1:0] CMD_BLOCK = 2'd0;
    localparam logic [1:0] CMD_IMAGE = 2'd1;
    localparam logic [1:0] CMD_PASS  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BAD_HEAD  = 3'd2;
    localparam logic [2:0] ST_BS_ZERO   = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    typedef enum logic [2:0]
    {
        K_BLOCK = 3'b001,
        K_IMAGE = 3'b010,
        K_PASS  = 3'b100
    } kind_t;

    typedef struct packed
    {
        kind_t       kind;
        logic        bno_ok;
        logic        hd_ok;
        logic        reg_ok;
        logic [3:0]  hd;
        logic [15:0] bno;
        logic [15:0] first;
        logic [15:0] width;
        logic [15:0] length;
    } item_t;

    typedef struct packed
    {
        logic  push;
        item_t item;
    } fifo_ctl_t;

endpackage

[hdl/pbat_ram.sv]
module pbat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/pbat_front.sv]
module pbat_front #(
    parameter int HEADS           = pbat_pkg::HEADS_DEF,
    parameter int BLOCKS_PER_HEAD = pbat_pkg::BLOCKS_DEF
) (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [1:0]                s_tuser,
    input  logic [pbat_pkg::IN_W-1:0] s_tdata,
    input  logic                      fifo_full,
    output pbat_pkg::fifo_ctl_t       wr
);

    import pbat_pkg::*;

    logic [31:0] first_ext;
    logic [31:0] base;

    assign s_tready  = !fifo_full;
    assign first_ext = {16'd0, s_tdata[35:20]};
    assign base      = {28'd0, s_tdata[19:16]} * 32'(BLOCKS_PER_HEAD);

    always_comb
    begin
        wr.item.bno    = s_tdata[15:0];
        wr.item.hd     = s_tdata[19:16];
        wr.item.first  = s_tdata[35:20];
        wr.item.width  = s_tdata[51:36];
        wr.item.length = s_tdata[67:52];
        wr.item.bno_ok = ({16'd0, s_tdata[15:0]} < 32'(HEADS * BLOCKS_PER_HEAD));
        wr.item.hd_ok  = ({28'd0, s_tdata[19:16]} < 32'(HEADS));
        wr.item.reg_ok = (first_ext >= base) && ((first_ext - base) < 32'(BLOCKS_PER_HEAD));
        wr.item.kind   = K_BLOCK;
        wr.push        = 1'b0;
        unique case (s_tuser)
            CMD_BLOCK:
            begin
                wr.item.kind = K_BLOCK;
                wr.push      = s_tvalid && s_tready;
            end
            CMD_IMAGE:
            begin
                wr.item.kind = K_IMAGE;
                wr.push      = s_tvalid && s_tready;
            end
            CMD_PASS:
            begin
                wr.item.kind = K_PASS;
                wr.push      = s_tvalid && s_tready;
            end
            default:
            begin
                wr.push = 1'b0;
            end
        endcase
    end

endmodule

[hdl/pbat_fifo.sv]
module pbat_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  pbat_pkg::fifo_ctl_t wr,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output pbat_pkg::item_t     head_item
);

    import pbat_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    item_t            mem_reg [FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == (PW+1)'(FIFO_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign do_push   = wr.push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr.item;
        end
    end

endmodule

[hdl/pbat_back.sv]
module pbat_back #(
    parameter int HEADS           = pbat_pkg::HEADS_DEF,
    parameter int BLOCKS_PER_HEAD = pbat_pkg::BLOCKS_DEF,
    parameter int QUEUE_DEPTH     = pbat_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [15:0]                cfg_wdata,
    input  logic                       fifo_empty,
    input  pbat_pkg::item_t            fifo_item,
    output logic                       fifo_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pbat_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tlast
);

    import pbat_pkg::*;

    localparam int TOTAL = HEADS * BLOCKS_PER_HEAD;
    localparam int AW    = $clog2(TOTAL);
    localparam int QAW   = $clog2(HEADS * QUEUE_DEPTH);
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int HW    = (HEADS > 1) ? $clog2(HEADS) : 1;
    localparam int PW    = $clog2(BLOCKS_PER_HEAD);
    localparam int LW    = $clog2(BLOCKS_PER_HEAD + 1);

    typedef enum logic [9:0]
    {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_IMG   = 10'b0000000100,
        S_HEAD  = 10'b0000001000,
        S_QRD   = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_SAT   = 10'b0001000000,
        S_RD    = 10'b0010000000,
        S_CHK   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [15:0]     bsize_reg;
    logic [AW-1:0]   clr_reg, clr_next;
    item_t           item_reg, item_next;
    logic [HW-1:0]   h_reg, h_next;
    logic            pass_reg, pass_next;
    logic [31:0]     bcount_reg, bcount_next;
    logic [QW-1:0]   qin_reg [HEADS];
    logic [QW-1:0]   qout_reg [HEADS];
    logic [31:0]     page_reg [HEADS];
    logic            qin_inc, qout_inc, page_inc;
    logic [31:0]     dvd_reg, dvd_next;
    logic [16:0]     rem_reg, rem_next;
    logic [4:0]      dcnt_reg, dcnt_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [LW-1:0]   left_reg, left_next;
    logic [LW-1:0]   miss_reg, miss_next;
    logic            found_reg, found_next;
    logic [AW-1:0]   fm_reg, fm_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic            ov_reg, ov_next;
    logic [2:0]      os_reg, os_next;
    logic [3:0]      oh_reg, oh_next;
    logic [13:0]     om_reg, om_next;
    logic [15:0]     of_reg, of_next;
    logic [31:0]     op_reg, op_next;
    logic            ol_reg, ol_next;

    logic            bm_we, bm_wdata, bm_rdata;
    logic [AW-1:0]   bm_waddr, bm_raddr;
    logic            q_we;
    logic [QAW-1:0]  q_waddr, q_raddr;
    logic [47:0]     q_rdata;

    logic [QW-1:0]   qin_cur, qout_cur, qin_adv, qout_adv;
    logic [31:0]     page_cur, base;
    logic [QAW-1:0]  qaddr_in, qaddr_out;
    logic [16:0]     rem_sh;
    logic [AW-1:0]   cur_addr;

    assign qin_cur   = qin_reg[h_reg];
    assign qout_cur  = qout_reg[h_reg];
    assign page_cur  = page_reg[h_reg];
    assign qin_adv   = (qin_cur == QW'(QUEUE_DEPTH - 1)) ? '0 : qin_cur + 1'b1;
    assign qout_adv  = (qout_cur == QW'(QUEUE_DEPTH - 1)) ? '0 : qout_cur + 1'b1;
    assign base      = 32'(h_reg) * 32'(BLOCKS_PER_HEAD);
    assign qaddr_in  = QAW'(32'(h_reg) * 32'(QUEUE_DEPTH) + 32'(qin_cur));
    assign qaddr_out = QAW'(32'(h_reg) * 32'(QUEUE_DEPTH) + 32'(qout_cur));
    assign rem_sh    = {rem_reg[15:0], dvd_reg[31]};
    assign cur_addr  = AW'(base + 32'(pos_reg));

    assign m_tvalid = ov_reg;
    assign m_tlast  = ol_reg;
    assign m_tdata  = {3'd0, bcount_reg, op_reg, of_reg, om_reg, oh_reg, os_reg};

    pbat_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_bitmap
    (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    pbat_ram #(.WIDTH(48), .DEPTH(HEADS * QUEUE_DEPTH)) u_imgq
    (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata ({item_reg.first, item_reg.width, item_reg.length}),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        item_next   = item_reg;
        h_next      = h_reg;
        pass_next   = pass_reg;
        bcount_next = bcount_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        miss_next   = miss_reg;
        found_next  = found_reg;
        fm_next     = fm_reg;
        addr_next   = addr_reg;
        ov_next     = ov_reg;
        os_next     = os_reg;
        oh_next     = oh_reg;
        om_next     = om_reg;
        of_next     = of_reg;
        op_next     = op_reg;
        ol_next     = ol_reg;
        qin_inc     = 1'b0;
        qout_inc    = 1'b0;
        page_inc    = 1'b0;
        fifo_pop    = 1'b0;
        bm_we       = 1'b0;
        bm_waddr    = addr_reg;
        bm_wdata    = 1'b0;
        bm_raddr    = cur_addr;
        q_we        = 1'b0;
        q_waddr     = qaddr_in;
        q_raddr     = qaddr_out;

        unique case (state_reg)
            S_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop  = 1'b1;
                    item_next = fifo_item;
                    om_next   = '0;
                    of_next   = '0;
                    op_next   = '0;
                    ol_next   = 1'b1;
                    oh_next   = '0;
                    case (fifo_item.kind)
                        K_BLOCK:
                        begin
                            ov_next    = 1'b1;
                            state_next = S_OUT;
                            pass_next  = 1'b0;
                            if (fifo_item.bno_ok)
                            begin
                                bm_we       = 1'b1;
                                bm_waddr    = AW'(fifo_item.bno);
                                bm_wdata    = 1'b1;
                                bcount_next = bcount_reg + 1'b1;
                                os_next     = ST_OK;
                            end
                            else
                            begin
                                os_next = ST_RANGE;
                            end
                        end
                        K_IMAGE:
                        begin
                            h_next     = HW'(fifo_item.hd);
                            pass_next  = 1'b0;
                            state_next = S_IMG;
                        end
                        default:
                        begin
                            h_next     = '0;
                            pass_next  = 1'b1;
                            state_next = S_HEAD;
                        end
                    endcase
                end
            end
            S_IMG:
            begin
                oh_next    = item_reg.hd;
                ov_next    = 1'b1;
                state_next = S_OUT;
                if (bsize_reg == '0)
                begin
                    os_next = ST_BS_ZERO;
                end
                else if (!item_reg.hd_ok)
                begin
                    os_next = ST_BAD_HEAD;
                end
                else if (!item_reg.reg_ok)
                begin
                    os_next = ST_RANGE;
                end
                else if (qin_adv == qout_cur)
                begin
                    os_next = ST_FULL;
                end
                else
                begin
                    q_we    = 1'b1;
                    qin_inc = 1'b1;
                    os_next = ST_OK;
                end
            end
            S_HEAD:
            begin
                oh_next = 4'(h_reg);
                om_next = '0;
                of_next = '0;
                op_next = page_cur;
                ol_next = (h_reg == HW'(HEADS - 1));
                if (qout_cur == qin_cur)
                begin
                    os_next    = ST_NONE;
                    ov_next    = 1'b1;
                    state_next = S_OUT;
                end
                else if (bsize_reg == '0)
                begin
                    os_next    = ST_BS_ZERO;
                    ov_next    = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_QRD;
                end
            end
            S_QRD:
            begin
                dvd_next   = q_rdata[31:16] * q_rdata[15:0];
                pos_next   = PW'({16'd0, q_rdata[47:32]} - base);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, bsize_reg})
                begin
                    rem_next = rem_sh - {1'b0, bsize_reg};
                    dvd_next = {dvd_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    dvd_next = {dvd_reg[30:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 5'd31)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                if (dvd_reg >= 32'(BLOCKS_PER_HEAD))
                begin
                    left_next = LW'(BLOCKS_PER_HEAD);
                end
                else
                begin
                    left_next = LW'(dvd_reg) + LW'(rem_reg != '0);
                end
                miss_next  = '0;
                found_next = 1'b0;
                fm_next    = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                if (left_reg == '0)
                begin
                    page_inc   = 1'b1;
                    qout_inc   = 1'b1;
                    os_next    = ST_OK;
                    om_next    = 14'(miss_reg);
                    of_next    = 16'(fm_reg);
                    op_next    = page_cur + 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    addr_next  = cur_addr;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!bm_rdata)
                begin
                    miss_next = miss_reg + 1'b1;
                    if (!found_reg)
                    begin
                        fm_next    = addr_reg;
                        found_next = 1'b1;
                    end
                end
                bm_we      = 1'b1;
                bm_waddr   = addr_reg;
                bm_wdata   = 1'b0;
                pos_next   = (pos_reg == PW'(BLOCKS_PER_HEAD - 1)) ? '0 : pos_reg + 1'b1;
                left_next  = left_reg - 1'b1;
                state_next = S_RD;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    ov_next = 1'b0;
                    if (pass_reg && (h_reg != HW'(HEADS - 1)))
                    begin
                        h_next     = h_reg + 1'b1;
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            bsize_reg  <= 16'd1;
            bcount_reg <= '0;
            ov_reg     <= 1'b0;
            pass_reg   <= 1'b0;
            h_reg      <= '0;
            for (int i = 0; i < HEADS; i++)
            begin
                qin_reg[i]  <= '0;
                qout_reg[i] <= '0;
                page_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            bcount_reg <= bcount_next;
            ov_reg     <= ov_next;
            pass_reg   <= pass_next;
            h_reg      <= h_next;
            if (cfg_wen)
            begin
                bsize_reg <= cfg_wdata;
            end
            if (qin_inc)
            begin
                qin_reg[h_reg] <= qin_adv;
            end
            if (qout_inc)
            begin
                qout_reg[h_reg] <= qout_adv;
            end
            if (page_inc)
            begin
                page_reg[h_reg] <= page_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        pos_reg   <= pos_next;
        left_reg  <= left_next;
        miss_reg  <= miss_next;
        found_reg <= found_next;
        fm_reg    <= fm_next;
        addr_reg  <= addr_next;
        os_reg    <= os_next;
        oh_reg    <= oh_next;
        om_reg    <= om_next;
        of_reg    <= of_next;
        op_reg    <= op_next;
        ol_reg    <= ol_next;
    end

endmodule

[hdl/print_block_arrival_tracker.sv]
// Print block arrival tracker. After reset the bitmap is swept clear, one block per cycle,
// all HEADS*BLOCKS_PER_HEAD blocks (40960 by default); up to two transactions are taken
// meanwhile, then s_tready stays low until the sweep ends. Transactions pass through a
// registered two-entry queue between the input and the executing back end. In the back end
// a block command is handled in the idle state and an image command in the image state
// after it, each then waiting for m_tready. A print pass visits each head in turn: when
// nothing is pending or the block size is zero, the head's result is given from the head
// state, otherwise a 32-step serial divider sizes the image in blocks and the bitmap memory
// is walked one block per read/clear state pair. Each head's result also waits for m_tready.
module print_block_arrival_tracker #(
    parameter int HEADS           = pbat_pkg::HEADS_DEF,
    parameter int BLOCKS_PER_HEAD = pbat_pkg::BLOCKS_DEF,
    parameter int QUEUE_DEPTH     = pbat_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [15:0]                cfg_wdata,  // block_size
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 s_tuser,    // cmd
    input  logic [pbat_pkg::IN_W-1:0]  s_tdata,    // block_no, head, first_block,
                                                   // width_bytes, length_px
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pbat_pkg::OUT_W-1:0] m_tdata,    // status, head_out, missing_count,
                                                   // first_missing, pages_printed,
                                                   // blocks_received
    output logic                       m_tlast
);

    import pbat_pkg::*;

    fifo_ctl_t wr;
    logic      fifo_full, fifo_empty, fifo_pop;
    item_t     fifo_item;

    pbat_front #(.HEADS(HEADS), .BLOCKS_PER_HEAD(BLOCKS_PER_HEAD)) u_front
    (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .fifo_full (fifo_full),
        .wr        (wr)
    );

    pbat_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .pop       (fifo_pop),
        .full      (fifo_full),
        .empty     (fifo_empty),
        .head_item (fifo_item)
    );

    pbat_back #(
        .HEADS           (HEADS),
        .BLOCKS_PER_HEAD (BLOCKS_PER_HEAD),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .fifo_empty (fifo_empty),
        .fifo_item  (fifo_item),
        .fifo_pop   (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[hdl/pbat_checker.sv]
module pbat_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [pbat_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tlast
);

    import pbat_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= ST_NONE)
        else $error("status code out of range");

    a_pass_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |->
            (m_tdata[2:0] == ST_OK) || (m_tdata[2:0] == ST_BS_ZERO) ||
            (m_tdata[2:0] == ST_NONE))
        else $error("non-final result with a non-pass status");

endmodule

bind print_block_arrival_tracker pbat_checker u_pbat_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
